// ===== rtl/cnv3_pkg.sv =====
`default_nettype none

package cnv3_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int COL_W     = $clog2(MAX_LINE);
    localparam int NUM_CH    = 3;
    localparam int KROWS     = 3;
    localparam int NUM_CELLS = 3;
    localparam int PIX_W     = 8;
    localparam int TAP_W     = 8;
    localparam int PROD_W    = PIX_W + TAP_W + 1;
    localparam int PSUM_W    = PROD_W + 2;
    localparam int SUM_W     = PSUM_W + 2;
    localparam int SCALE_W   = 16;
    localparam int MUL_W     = SUM_W + SCALE_W + 1;
    localparam int T_W       = MUL_W + 1;
    localparam int FRAC_W    = 19;
    localparam int OFFSET_W  = 9;
    localparam int WIDTH_W   = 11;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET = 3'd5;

    // row phase codes
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_LATER  = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_of_run;
        logic             frame_done;
    } out_t;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;
    // row 0 top, 1 middle, 2 bottom
    typedef pix_t [KROWS-1:0] col_t;
    typedef logic [KROWS-1:0][TAP_W-1:0] tapcol_t;
    typedef logic [NUM_CH-1:0][PSUM_W-1:0] psum_t;

    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_entry_t;

    typedef struct packed {
        logic last_of_run;
        logic frame_done;
    } tok_t;

    function automatic logic signed [PSUM_W-1:0] tap_mul(
        input logic [TAP_W-1:0] tap,
        input logic [PIX_W-1:0] px
    );
        logic signed [PROD_W-1:0] p;
        p = $signed(tap) * $signed({1'b0, px});
        return PSUM_W'(p);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cnv3_cell.sv =====
`default_nettype none

// One window column: holds three pixels and forms their weighted sum per channel.
module cnv3_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              shift_en,
    input  wire cnv3_pkg::col_t    col_in,
    input  wire cnv3_pkg::tapcol_t taps,
    output cnv3_pkg::col_t         col_out,
    output cnv3_pkg::psum_t        psum
);

    cnv3_pkg::col_t  col_reg;
    cnv3_pkg::col_t  col_next;
    cnv3_pkg::psum_t psum_reg;
    cnv3_pkg::psum_t psum_next;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_comb begin
        for (int ch = 0; ch < cnv3_pkg::NUM_CH; ch++) begin
            psum_next[ch] = '0;
            for (int k = 0; k < cnv3_pkg::KROWS; k++) begin
                psum_next[ch] = psum_next[ch] + cnv3_pkg::tap_mul(taps[k], col_reg[k][ch]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

`default_nettype wire

// ===== rtl/cnv3_scale.sv =====
`default_nettype none

// Adds the column sums, applies the reciprocal scale, offset, rounding and clamp.
module cnv3_scale (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    input  wire cnv3_pkg::tok_t                    in_tok,
    input  wire cnv3_pkg::psum_t                   psum [cnv3_pkg::NUM_CELLS],
    input  wire logic [cnv3_pkg::SCALE_W-1:0]      scale,
    input  wire logic [cnv3_pkg::OFFSET_W-1:0]     offset,
    output logic                                   out_valid,
    output cnv3_pkg::out_t                         out_data
);

    localparam logic [cnv3_pkg::T_W-1:0] ROUND_HALF =
        cnv3_pkg::T_W'(1) << (cnv3_pkg::FRAC_W - 1);
    localparam int HI_LSB = cnv3_pkg::FRAC_W + cnv3_pkg::PIX_W;

    logic signed [cnv3_pkg::SUM_W-1:0] sum_reg  [cnv3_pkg::NUM_CH];
    logic signed [cnv3_pkg::SUM_W-1:0] sum_next [cnv3_pkg::NUM_CH];
    logic signed [cnv3_pkg::MUL_W-1:0] prod_reg [cnv3_pkg::NUM_CH];
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    cnv3_pkg::tok_t s1_tok_reg;
    cnv3_pkg::tok_t s2_tok_reg;
    logic [cnv3_pkg::PIX_W-1:0] res [cnv3_pkg::NUM_CH];

    always_comb begin
        for (int ch = 0; ch < cnv3_pkg::NUM_CH; ch++) begin
            sum_next[ch] = '0;
            for (int i = 0; i < cnv3_pkg::NUM_CELLS; i++) begin
                sum_next[ch] = sum_next[ch] + cnv3_pkg::SUM_W'($signed(psum[i][ch]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < cnv3_pkg::NUM_CH; ch++) begin
            sum_reg[ch]  <= sum_next[ch];
            prod_reg[ch] <= sum_reg[ch] * $signed({1'b0, scale});
        end
        s1_tok_reg <= in_tok;
        s2_tok_reg <= s1_tok_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // t is in units of 2^-19 pixel; round half up, then clamp to 0..255
    always_comb begin
        logic [cnv3_pkg::T_W-1:0] t;
        for (int ch = 0; ch < cnv3_pkg::NUM_CH; ch++) begin
            t = cnv3_pkg::T_W'(prod_reg[ch])
                + (cnv3_pkg::T_W'($signed(offset)) << cnv3_pkg::FRAC_W)
                + ROUND_HALF;
            if (t[cnv3_pkg::T_W-1]) begin
                res[ch] = '0;
            end else if (|t[cnv3_pkg::T_W-2:HI_LSB]) begin
                res[ch] = '1;
            end else begin
                res[ch] = t[HI_LSB-1:cnv3_pkg::FRAC_W];
            end
        end
    end

    always_comb begin
        out_data.red_out     = res[0];
        out_data.green_out   = res[1];
        out_data.blue_out    = res[2];
        out_data.last_of_run = s2_tok_reg.last_of_run;
        out_data.frame_done  = s2_tok_reg.frame_done;
    end

    assign out_valid = s2_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/cnv3_out_fifo.sv =====
`default_nettype none

module cnv3_out_fifo (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire cnv3_pkg::out_t               push_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cnv3_pkg::out_t                    m_data,
    output logic [cnv3_pkg::CNT_W-1:0]        count
);

    cnv3_pkg::out_t                 entry_reg [cnv3_pkg::OUT_DEPTH];
    logic [cnv3_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [cnv3_pkg::PTR_W-1:0]     wr_ptr_next;
    logic [cnv3_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [cnv3_pkg::PTR_W-1:0]     rd_ptr_next;
    logic [cnv3_pkg::CNT_W-1:0]     count_reg;
    logic [cnv3_pkg::CNT_W-1:0]     count_next;
    logic                           pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

// ===== rtl/conv3x3_rgb_stream_filter_unit.sv =====
// 3x3 convolution over a raster-order RGB pixel stream, 8 bits a channel.
// s_ channel: one pixel per transfer; kind = 1 marks the padding row sent after
// the frame to flush its last line. m_ channel: filtered pixels, one line up and
// one column behind; a line end gives two results, last_of_run marks the final
// result of each input pixel and frame_done the final result of the frame.
// cfg_we/cfg_index/cfg_wdata write width, kernel rows, scale and offset; write
// them only while the block is idle.
// The line memory is single-port: it is read when a pixel is accepted and written in
// ST_LOAD, and at a line end past the first row the column cells shift the second
// line-end window in ST_TAIL; s_ready is low in both states, so a new pixel waits for ST_IDLE.
// Results pass a 4-entry output queue; inputs keep flowing while results wait, and
// s_ready also drops when the queue could not hold two more results.
// Reset (aresetn low, synchronous) restores default registers (one tap of 16 at the
// middle row, left column; width 1024) and starts a new frame at row 0, column 0.
// The line memory is not cleared: rows are read only after the frame has written them.
`default_nettype none

module conv3x3_rgb_stream_filter_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire cnv3_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output cnv3_pkg::out_t                        m_data,
    input  wire logic                             cfg_we,
    input  wire logic [cnv3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cnv3_pkg::CFG_W-1:0]       cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_TAIL = 3'b100
    } state_t;

    // configuration
    logic [cnv3_pkg::WIDTH_W-1:0]   width_reg;
    logic [cnv3_pkg::CFG_W-1:0]     kernel_reg [cnv3_pkg::KROWS];
    logic [cnv3_pkg::SCALE_W-1:0]   scale_reg;
    logic [cnv3_pkg::OFFSET_W-1:0]  offset_reg;

    state_t                         state_reg;
    state_t                         state_next;
    logic [cnv3_pkg::COL_W-1:0]     col_cnt_reg;
    logic [cnv3_pkg::COL_W-1:0]     col_cnt_next;
    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [cnv3_pkg::COL_W-1:0]     last_col;

    cnv3_pkg::pix_t                 pix_reg;
    logic                           pad_reg;
    logic                           line_end_reg;
    cnv3_pkg::line_entry_t          mem_rd_reg;
    cnv3_pkg::line_entry_t          line_mem [cnv3_pkg::MAX_LINE];

    logic                           accept;
    logic                           mem_we;
    cnv3_pkg::pix_t                 top_pix;
    cnv3_pkg::pix_t                 mid_pix;
    cnv3_pkg::col_t                 new_col;

    cnv3_pkg::col_t                 cell_in  [cnv3_pkg::NUM_CELLS];
    cnv3_pkg::col_t                 cell_out [cnv3_pkg::NUM_CELLS];
    cnv3_pkg::tapcol_t              cell_taps [cnv3_pkg::NUM_CELLS];
    cnv3_pkg::psum_t                cell_psum [cnv3_pkg::NUM_CELLS];
    logic                           shift_en;

    logic                           launch;
    cnv3_pkg::tok_t                 launch_tok;
    logic                           tok0_v_reg;
    cnv3_pkg::tok_t                 tok0_reg;
    logic                           tok1_v_reg;
    cnv3_pkg::tok_t                 tok1_reg;

    logic                           push;
    cnv3_pkg::out_t                 push_data;
    logic [cnv3_pkg::CNT_W-1:0]     fifo_count;
    logic [cnv3_pkg::CNT_W-1:0]     inflight_reg;
    logic [cnv3_pkg::CNT_W-1:0]     inflight_next;
    logic [cnv3_pkg::CNT_W:0]       outstanding;

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= cnv3_pkg::WIDTH_W'(1024);
            kernel_reg[0] <= '0;
            kernel_reg[1] <= cnv3_pkg::CFG_W'(16);
            kernel_reg[2] <= '0;
            scale_reg     <= cnv3_pkg::SCALE_W'(32768);
            offset_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                cnv3_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[cnv3_pkg::WIDTH_W-1:0];
                end
                cnv3_pkg::CFG_KERNEL_TOP: begin
                    kernel_reg[0] <= cfg_wdata;
                end
                cnv3_pkg::CFG_KERNEL_MIDDLE: begin
                    kernel_reg[1] <= cfg_wdata;
                end
                cnv3_pkg::CFG_KERNEL_BOTTOM: begin
                    kernel_reg[2] <= cfg_wdata;
                end
                cnv3_pkg::CFG_SCALE_FACTOR: begin
                    scale_reg <= cfg_wdata[cnv3_pkg::SCALE_W-1:0];
                end
                cnv3_pkg::CFG_RESULT_OFFSET: begin
                    offset_reg <= cfg_wdata[cnv3_pkg::OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // width 0 acts as 1, widths beyond the line memory act as its depth
    always_comb begin
        if (width_reg == '0) begin
            last_col = '0;
        end else if (32'(width_reg) > cnv3_pkg::MAX_LINE) begin
            last_col = cnv3_pkg::COL_W'(cnv3_pkg::MAX_LINE - 1);
        end else begin
            last_col = cnv3_pkg::COL_W'(width_reg - 1'b1);
        end
    end

    // ---------------- sequencer ----------------
    assign outstanding = {1'b0, inflight_reg} + {1'b0, fifo_count};
    assign s_ready     = (state_reg == ST_IDLE) &&
                         (outstanding <= (cnv3_pkg::CNT_W + 1)'(cnv3_pkg::OUT_DEPTH - 2));
    assign accept      = s_valid && s_ready;

    always_comb begin
        top_pix = (phase_reg == cnv3_pkg::PHASE_LATER) ? mem_rd_reg.upper : '0;
        mid_pix = (phase_reg != cnv3_pkg::PHASE_FIRST) ? mem_rd_reg.lower : '0;
        new_col[0] = top_pix;
        new_col[1] = mid_pix;
        new_col[2] = pix_reg;
    end

    assign mem_we = (state_reg == ST_LOAD);

    always_comb begin
        state_next   = state_reg;
        col_cnt_next = col_cnt_reg;
        phase_next   = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (line_end_reg && phase_reg != cnv3_pkg::PHASE_FIRST) begin
                    state_next = ST_TAIL;
                end else begin
                    state_next = ST_IDLE;
                end
                if (line_end_reg) begin
                    col_cnt_next = '0;
                    if (pad_reg) begin
                        phase_next = cnv3_pkg::PHASE_FIRST;
                    end else if (phase_reg == cnv3_pkg::PHASE_FIRST) begin
                        phase_next = cnv3_pkg::PHASE_SECOND;
                    end else begin
                        phase_next = cnv3_pkg::PHASE_LATER;
                    end
                end else begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
            end
            ST_TAIL: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_cnt_reg <= '0;
            phase_reg   <= cnv3_pkg::PHASE_FIRST;
        end else begin
            state_reg   <= state_next;
            col_cnt_reg <= col_cnt_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg      <= s_data.kind ? '0 :
                            cnv3_pkg::pix_t'({s_data.blue_in, s_data.green_in, s_data.red_in});
            pad_reg      <= s_data.kind;
            line_end_reg <= (col_cnt_reg >= last_col);
        end
    end

    // line memory: upper holds row r-2, lower row r-1
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[col_cnt_reg] <= '{upper: mid_pix, lower: pix_reg};
        end
        if (accept) begin
            mem_rd_reg <= line_mem[col_cnt_reg];
        end
    end

    // ---------------- column cells ----------------
    // cell 0 is the right column, cell 2 the left; the line-end window shifts in zeros
    assign shift_en = (state_reg == ST_LOAD) || (state_reg == ST_TAIL);

    always_comb begin
        cell_in[0] = (state_reg == ST_LOAD) ? new_col : '0;
        for (int i = 1; i < cnv3_pkg::NUM_CELLS; i++) begin
            cell_in[i] = (state_reg == ST_LOAD && col_cnt_reg == '0) ? '0 : cell_out[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < cnv3_pkg::NUM_CELLS; i++) begin
            for (int k = 0; k < cnv3_pkg::KROWS; k++) begin
                cell_taps[i][k] = kernel_reg[k][cnv3_pkg::TAP_W*(cnv3_pkg::NUM_CELLS-1-i) +:
                                                cnv3_pkg::TAP_W];
            end
        end
    end

    for (genvar g = 0; g < cnv3_pkg::NUM_CELLS; g++) begin : g_cell
        cnv3_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .col_in   (cell_in[g]),
            .taps     (cell_taps[g]),
            .col_out  (cell_out[g]),
            .psum     (cell_psum[g])
        );
    end

    // ---------------- result tokens ----------------
    always_comb begin
        launch     = 1'b0;
        launch_tok = '0;
        case (state_reg)
            ST_LOAD: begin
                launch = (phase_reg != cnv3_pkg::PHASE_FIRST) && (col_cnt_reg != '0);
                launch_tok.last_of_run = !line_end_reg;
            end
            ST_TAIL: begin
                launch = 1'b1;
                launch_tok.last_of_run = 1'b1;
                launch_tok.frame_done  = pad_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok0_v_reg   <= 1'b0;
            tok1_v_reg   <= 1'b0;
            inflight_reg <= '0;
        end else begin
            tok0_v_reg   <= launch;
            tok1_v_reg   <= tok0_v_reg;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok0_reg <= launch_tok;
        tok1_reg <= tok0_reg;
    end

    always_comb begin
        inflight_next = inflight_reg;
        if (launch && !push) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (push && !launch) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    cnv3_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tok1_v_reg),
        .in_tok    (tok1_reg),
        .psum      (cell_psum),
        .scale     (scale_reg),
        .offset    (offset_reg),
        .out_valid (push),
        .out_data  (push_data)
    );

    cnv3_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count)
    );

    // ---------------- assertions ----------------
    a_no_overcommit: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding <= (cnv3_pkg::CNT_W + 1)'(cnv3_pkg::OUT_DEPTH))
        else $error("results in flight exceed output queue depth");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count < cnv3_pkg::CNT_W'(cnv3_pkg::OUT_DEPTH) || (m_valid && m_ready)))
        else $error("result pushed into full output queue");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted pixel not loaded next cycle");

    a_tail_after_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) |-> ($past(state_reg) == ST_LOAD && line_end_reg))
        else $error("line-end window without a line-end pixel");

endmodule

`default_nettype wire
